@@ src/frp_pkg.sv @@
// types and constants shared by the fail-safe ramp output gate
// no dependencies

package frp_pkg;

  localparam int unsigned TIME_W        = 32;  // millisecond clock width
  localparam int unsigned DUR_W         = 16;  // hold duration width
  localparam int unsigned NEUTRAL_CFG_W = 12;  // neutral pulse register width
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUR = 1'd1;

  localparam logic [NEUTRAL_CFG_W-1:0] NEUTRAL_RESET  = 12'd1500;
  localparam logic [DUR_W-1:0]         HOLD_DUR_RESET = 16'd500;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_CUT    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
  } lane_ctrl_t;

endpackage

@@ src/frp_if.sv @@
// handshake channels of the fail-safe ramp output gate: input beat, result beat, config write
// depends on frp_pkg

interface frp_in_if #(
  parameter int unsigned PULSE_BITS = 12
);
  logic                        valid;
  logic                        ready;
  logic                        drive_allowed;
  logic [PULSE_BITS-1:0]       commanded_left;
  logic [PULSE_BITS-1:0]       commanded_right;
  logic [PULSE_BITS-1:0]       current_left;
  logic [PULSE_BITS-1:0]       current_right;
  logic [frp_pkg::TIME_W-1:0]  now_ms;

  modport source (
    output valid, drive_allowed, commanded_left, commanded_right,
           current_left, current_right, now_ms,
    input  ready
  );
  modport sink (
    input  valid, drive_allowed, commanded_left, commanded_right,
           current_left, current_right, now_ms,
    output ready
  );
endinterface

interface frp_out_if #(
  parameter int unsigned PULSE_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  write_valid;
  logic                  attach_req;
  logic                  detach_req;
  logic [PULSE_BITS-1:0] left_pulse;
  logic [PULSE_BITS-1:0] right_pulse;

  modport source (
    output valid, write_valid, attach_req, detach_req, left_pulse, right_pulse,
    input  ready
  );
  modport sink (
    input  valid, write_valid, attach_req, detach_req, left_pulse, right_pulse,
    output ready
  );
endinterface

interface frp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frp_pkg::CFG_IDX_W-1:0]   index;
  logic [frp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/frp_lane.sv @@
// one ramp lane: bit-serial multiply of |neutral - from| by elapsed, then
// restoring divide by the duration, one bit per cycle; depends on frp_pkg

module frp_lane #(
  parameter int unsigned PULSE_BITS = 12
) (
  input  logic                        clk_i,
  input  frp_pkg::lane_ctrl_t         ctrl_i,
  input  logic [PULSE_BITS-1:0]       neutral_i,
  input  logic [PULSE_BITS-1:0]       from_i,
  input  logic [frp_pkg::DUR_W-1:0]   elapsed_i,
  input  logic [frp_pkg::DUR_W-1:0]   dur_i,
  output logic [PULSE_BITS-1:0]       pulse_o
);
  import frp_pkg::*;

  localparam int unsigned ACC_W = PULSE_BITS + DUR_W + 1;

  logic [PULSE_BITS-1:0] from_q, from_d;
  logic [PULSE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [ACC_W-1:0]      acc_q, acc_d;

  logic [PULSE_BITS:0]   diff;
  logic [PULSE_BITS:0]   diff_neg;
  logic [PULSE_BITS:0]   hi_sum;
  logic [DUR_W:0]        trial;
  logic [DUR_W:0]        trial_sub;
  logic                  q_bit;
  logic [DUR_W-1:0]      rem_d;
  logic [PULSE_BITS-1:0] quot;

  always_comb begin
    diff      = {1'b0, neutral_i} - {1'b0, from_i};
    diff_neg  = -diff;
    // multiply step: add magnitude into the upper half when the multiplier bit is set
    hi_sum    = acc_q[ACC_W-1:DUR_W] + (acc_q[0] ? {1'b0, mag_q} : '0);
    // divide step: partial remainder with the next dividend bit
    trial     = acc_q[ACC_W-2:PULSE_BITS-1];
    trial_sub = trial - {1'b0, dur_i};
    q_bit     = (trial >= {1'b0, dur_i});
    rem_d     = q_bit ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];

    from_d = from_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    if (ctrl_i.load) begin
      from_d = from_i;
      neg_d  = diff[PULSE_BITS];
      mag_d  = diff[PULSE_BITS] ? diff_neg[PULSE_BITS-1:0] : diff[PULSE_BITS-1:0];
      acc_d  = {{(PULSE_BITS+1){1'b0}}, elapsed_i};
    end else if (ctrl_i.mul) begin
      acc_d  = {1'b0, hi_sum, acc_q[DUR_W-1:1]};
    end else if (ctrl_i.div) begin
      acc_d  = {1'b0, rem_d, acc_q[PULSE_BITS-2:0], q_bit};
    end
  end

  always_ff @(posedge clk_i) begin
    from_q <= from_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
  end

  // quotient magnitude truncates toward zero, sign applied afterwards
  assign quot    = acc_q[PULSE_BITS-1:0];
  assign pulse_o = neg_q ? (from_q - quot) : (from_q + quot);

endmodule

@@ src/failsafe_ramp_output_gate_core.sv @@
// top level of the fail-safe ramp output gate: mode control, config registers, result register
// depends on frp_pkg, frp_if (channel interfaces) and frp_lane

// One input beat gives exactly one result beat. While drive is allowed the commanded pulses
// pass straight through (attach_req set on the first beat after a cut); when drive is lost
// the current pulses and now_ms are latched and each side ramps linearly to neutral_pulse
// over hold_duration_ms, ending with detach_req and a silent cut mode. One beat is handled
// at a time. A pass-through, cut or end-of-ramp beat goes from acceptance through the done
// state into the output register; a beat that is mid-ramp first runs through the two
// bit-serial lanes: shift-add multiply by the elapsed time, then restoring division by the
// duration, then the fin state. The input is taken again as soon as the result has moved
// into the output register, even if that result is still waiting.
// Config writes are always ready and must only be made while the block is idle.

module failsafe_ramp_output_gate_core #(
  parameter int unsigned PULSE_BITS = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  frp_cfg_if.sink in_cfg_i,
  frp_in_if.sink  in_i,
  frp_out_if.source out_o
);
  import frp_pkg::*;

  localparam int unsigned MAX_STEPS = (DUR_W > PULSE_BITS) ? DUR_W : PULSE_BITS;
  localparam int unsigned CNT_W     = $clog2(MAX_STEPS + 1);

  // config registers
  logic [PULSE_BITS-1:0] neutral_q;
  logic [DUR_W-1:0]      hold_dur_q;

  // gate state
  mode_e                 mode_q, mode_d;
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_W-1:0]     hold_start_q;
  logic [PULSE_BITS-1:0] ramp_left_q;
  logic [PULSE_BITS-1:0] ramp_right_q;

  // pending result, waiting for the output register
  logic                  res_wr_q, res_att_q, res_det_q;
  logic [PULSE_BITS-1:0] res_left_q, res_right_q;

  // output register
  logic                  out_valid_q;
  logic                  out_wr_q, out_att_q, out_det_q;
  logic [PULSE_BITS-1:0] out_left_q, out_right_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  fresh_hold;
  logic                  in_ramp_mode;
  logic [TIME_W-1:0]     elapsed;
  logic                  sat;
  logic [PULSE_BITS-1:0] from_left, from_right;
  logic [PULSE_BITS-1:0] lane_left, lane_right;
  lane_ctrl_t            lane_ctrl;

  // ---------------------------------------------------------------------------
  // config port
  // ---------------------------------------------------------------------------
  assign in_cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q  <= PULSE_BITS'(NEUTRAL_RESET);
      hold_dur_q <= HOLD_DUR_RESET;
    end else if (in_cfg_i.valid) begin
      case (in_cfg_i.index)
        REG_NEUTRAL:  neutral_q  <= PULSE_BITS'(in_cfg_i.data[NEUTRAL_CFG_W-1:0]);
        REG_HOLD_DUR: hold_dur_q <= in_cfg_i.data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // beat decode at acceptance
  // ---------------------------------------------------------------------------
  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;

  // drive lost while active: ramp starts now from the current pulses
  assign fresh_hold   = (mode_q == MODE_ACTIVE);
  assign in_ramp_mode = (mode_q == MODE_ACTIVE) || (mode_q == MODE_HOLD);
  // wrapping difference, zero on the beat that starts the hold
  assign elapsed      = fresh_hold ? '0 : (in_i.now_ms - hold_start_q);
  // elapsed reached the duration (always so for zero duration): output sits at neutral
  assign sat          = (elapsed >= {{(TIME_W-DUR_W){1'b0}}, hold_dur_q});

  assign from_left    = fresh_hold ? in_i.current_left  : ramp_left_q;
  assign from_right   = fresh_hold ? in_i.current_right : ramp_right_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    mode_d         = mode_q;
    lane_ctrl.load = 1'b0;
    lane_ctrl.mul  = (state_q == ST_MUL);
    lane_ctrl.div  = (state_q == ST_DIV);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.drive_allowed) begin
            mode_d  = MODE_ACTIVE;
            state_d = ST_DONE;
          end else if (in_ramp_mode) begin
            mode_d = sat ? MODE_CUT : MODE_HOLD;
            if (sat) begin
              state_d = ST_DONE;
            end else begin
              lane_ctrl.load = 1'b1;
              cnt_d          = '0;
              state_d        = ST_MUL;
            end
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DUR_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PULSE_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_ACTIVE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
    end
  end

  // ramp start point and time, latched when the hold begins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_start_q <= '0;
      ramp_left_q  <= '0;
      ramp_right_q <= '0;
    end else if (in_acc && !in_i.drive_allowed && fresh_hold) begin
      hold_start_q <= in_i.now_ms;
      ramp_left_q  <= in_i.current_left;
      ramp_right_q <= in_i.current_right;
    end
  end

  // ---------------------------------------------------------------------------
  // ramp lanes, one per side
  // ---------------------------------------------------------------------------
  frp_lane #(
    .PULSE_BITS (PULSE_BITS)
  ) u_lane_left (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .neutral_i (neutral_q),
    .from_i    (from_left),
    .elapsed_i (elapsed[DUR_W-1:0]),
    .dur_i     (hold_dur_q),
    .pulse_o   (lane_left)
  );

  frp_lane #(
    .PULSE_BITS (PULSE_BITS)
  ) u_lane_right (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .neutral_i (neutral_q),
    .from_i    (from_right),
    .elapsed_i (elapsed[DUR_W-1:0]),
    .dur_i     (hold_dur_q),
    .pulse_o   (lane_right)
  );

  // ---------------------------------------------------------------------------
  // pending result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      if (in_i.drive_allowed) begin
        // pass-through; attach only when resuming from a cut
        res_wr_q    <= 1'b1;
        res_att_q   <= (mode_q == MODE_CUT);
        res_det_q   <= 1'b0;
        res_left_q  <= in_i.commanded_left;
        res_right_q <= in_i.commanded_right;
      end else if (in_ramp_mode && sat) begin
        // ramp complete: neutral on both sides and stop the outputs
        res_wr_q    <= 1'b1;
        res_att_q   <= 1'b0;
        res_det_q   <= 1'b1;
        res_left_q  <= neutral_q;
        res_right_q <= neutral_q;
      end else begin
        // cut: nothing written, pulses zero (overwritten in fin when ramping)
        res_wr_q    <= 1'b0;
        res_att_q   <= 1'b0;
        res_det_q   <= 1'b0;
        res_left_q  <= '0;
        res_right_q <= '0;
      end
    end else if (state_q == ST_FIN) begin
      res_wr_q    <= 1'b1;
      res_att_q   <= 1'b0;
      res_det_q   <= 1'b0;
      res_left_q  <= lane_left;
      res_right_q <= lane_right;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_wr_q    <= res_wr_q;
      out_att_q   <= res_att_q;
      out_det_q   <= res_det_q;
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.write_valid = out_wr_q;
  assign out_o.attach_req  = out_att_q;
  assign out_o.detach_req  = out_det_q;
  assign out_o.left_pulse  = out_left_q;
  assign out_o.right_pulse = out_right_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // detach only comes with a final neutral write and never with attach
  a_detach_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.detach_req |-> out_o.write_valid && !out_o.attach_req)
    else $error("detach beat without write or with attach");

  // a beat that writes nothing carries zero pulses
  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.write_valid |-> out_o.left_pulse == '0 && out_o.right_pulse == '0)
    else $error("non-writing beat with non-zero pulses");

  // drive allowed always returns the gate to active
  a_allowed_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.drive_allowed |=> mode_q == MODE_ACTIVE)
    else $error("gate not active after an allowed beat");

  // the lanes only run while holding
  a_ramp_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV || state_q == ST_FIN) |-> mode_q == MODE_HOLD)
    else $error("ramp arithmetic outside hold mode");

endmodule

@@ sim/tb_failsafe_ramp_output_gate_core.sv @@
// self-checking testbench for failsafe_ramp_output_gate_core: directed and random beats,
// predicted by a scoreboard class that models the gate modes and the linear ramp
// depends on frp_pkg, frp_if (channel interfaces) and the core itself

module tb_failsafe_ramp_output_gate_core;
  timeunit 1ns;
  timeprecision 1ps;

  import frp_pkg::*;

  localparam int unsigned PB              = 12;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned PHASE_BEATS     = 105;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_CYCLES    = 40;   // quiet cycles after the last owed result, before the verdict

  // one input beat as the sender builds it
  typedef struct packed {
    logic              drive_allowed;
    logic [PB-1:0]     commanded_left;
    logic [PB-1:0]     commanded_right;
    logic [PB-1:0]     current_left;
    logic [PB-1:0]     current_right;
    logic [TIME_W-1:0] now_ms;
  } gate_beat_t;

  // one result beat
  typedef struct packed {
    logic          write_valid;
    logic          attach_req;
    logic          detach_req;
    logic [PB-1:0] left_pulse;
    logic [PB-1:0] right_pulse;
  } pulse_result_t;

  // tracks the gate mode, the latched ramp start and the registers, and holds the
  // pulse results still owed by the core in order
  class pulse_gate_scoreboard;
    pulse_result_t            expected_q[$];
    mode_e                    mode;
    logic [TIME_W-1:0]        hold_start;
    logic [PB-1:0]            ramp_from_left;
    logic [PB-1:0]            ramp_from_right;
    logic [NEUTRAL_CFG_W-1:0] neutral;
    logic [DUR_W-1:0]         hold_dur;
    int unsigned              error_count;

    function new();
      mode            = MODE_ACTIVE;
      hold_start      = '0;
      ramp_from_left  = '0;
      ramp_from_right = '0;
      neutral         = NEUTRAL_RESET;
      hold_dur        = HOLD_DUR_RESET;
      error_count     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NEUTRAL:  neutral  = data[NEUTRAL_CFG_W-1:0];
        REG_HOLD_DUR: hold_dur = data[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    // from + (neutral - from) * e / dur, quotient truncated toward zero
    function logic [PB-1:0] ramp_towards_neutral(logic [PB-1:0] from, logic [TIME_W-1:0] e);
      longint diff;
      longint delta;
      diff = longint'(neutral) - longint'(from);
      if (hold_dur == '0) delta = diff;
      else delta = (diff * longint'(e)) / longint'(hold_dur);
      return PB'(longint'(from) + delta);
    endfunction

    function void note_command(gate_beat_t b);
      pulse_result_t     r;
      logic [TIME_W-1:0] e;
      r = '0;
      if (b.drive_allowed) begin
        if (mode == MODE_CUT) r.attach_req = 1'b1;
        mode          = MODE_ACTIVE;
        r.write_valid = 1'b1;
        r.left_pulse  = b.commanded_left;
        r.right_pulse = b.commanded_right;
      end else begin
        if (mode == MODE_ACTIVE) begin
          mode            = MODE_HOLD;
          hold_start      = b.now_ms;
          ramp_from_left  = b.current_left;
          ramp_from_right = b.current_right;
        end
        if (mode == MODE_HOLD) begin
          // wrapping difference, saturated at the ramp length
          e = b.now_ms - hold_start;
          if (e > TIME_W'(hold_dur)) e = TIME_W'(hold_dur);
          r.write_valid = 1'b1;
          r.left_pulse  = ramp_towards_neutral(ramp_from_left, e);
          r.right_pulse = ramp_towards_neutral(ramp_from_right, e);
          if (e >= TIME_W'(hold_dur)) begin
            r.detach_req = 1'b1;
            mode         = MODE_CUT;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_output(pulse_result_t got);
      pulse_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("write_valid", want.write_valid, got.write_valid);
      compare_field("attach_req", want.attach_req, got.attach_req);
      compare_field("detach_req", want.detach_req, got.detach_req);
      compare_field("left_pulse", want.left_pulse, got.left_pulse);
      compare_field("right_pulse", want.right_pulse, got.right_pulse);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  frp_in_if  #(.PULSE_BITS(PB)) in_if ();
  frp_out_if #(.PULSE_BITS(PB)) out_if ();
  frp_cfg_if                    cfg_if ();

  failsafe_ramp_output_gate_core #(
    .PULSE_BITS(PB)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_cfg_i(cfg_if),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  pulse_gate_scoreboard sb = new();

  int unsigned beats_sent   = 0;
  int unsigned burst_left   = 0;   // sender beats still to go back to back
  bit          hold_off_req = 1'b0;  // asks the result side for one long stall

  always #10 clk_i = ~clk_i;

  // sender gap: mostly none or short, a few long, and now and then a run with no gaps
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic gate_beat_t make_beat(logic allowed, logic [TIME_W-1:0] now,
                                           logic [PB-1:0] cur_l, logic [PB-1:0] cur_r);
    gate_beat_t b;
    b.drive_allowed   = allowed;
    b.commanded_left  = PB'($urandom());
    b.commanded_right = PB'($urandom());
    b.current_left    = cur_l;
    b.current_right   = cur_r;
    b.now_ms          = now;
    return b;
  endfunction

  function automatic logic [PB-1:0] any_pulse();
    return PB'($urandom());
  endfunction

  // valid stays up from one beat to the next when there is no gap
  task automatic send_beat(input gate_beat_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.drive_allowed   <= b.drive_allowed;
    in_if.commanded_left  <= b.commanded_left;
    in_if.commanded_right <= b.commanded_right;
    in_if.current_left    <= b.current_left;
    in_if.current_right   <= b.current_right;
    in_if.now_ms          <= b.now_ms;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(b);
    beats_sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_register(idx, data);
  endtask

  // both registers, neutral with junk in the unused upper bits
  task automatic apply_gate_config(input logic [NEUTRAL_CFG_W-1:0] neutral,
                                   input logic [DUR_W-1:0] dur);
    write_register(REG_NEUTRAL, {4'($urandom_range(0, 15)), neutral});
    write_register(REG_HOLD_DUR, CFG_DATA_W'(dur));
    cfg_if.valid <= 1'b0;
  endtask

  // stop offering, then wait for every owed result and the given number of quiet cycles
  task automatic wait_idle(input int unsigned settle);
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // a well-formed drive loss: drive allowed, then a ramp sampled at rising times,
  // usually run to its end and followed by a few cut beats
  task automatic run_episode(inout logic [TIME_W-1:0] clock_ms);
    int unsigned       dur;
    int unsigned       n_hold;
    logic [TIME_W-1:0] ramp_t0;
    logic [TIME_W-1:0] t;
    dur = sb.hold_dur;
    repeat ($urandom_range(1, 3)) begin
      send_beat(make_beat(1'b1, clock_ms, any_pulse(), any_pulse()));
      clock_ms += $urandom_range(0, 2);
    end
    // now and then start just short of the wrap so the ramp crosses it
    if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, dur);
    ramp_t0 = clock_ms;
    t       = clock_ms;
    n_hold  = $urandom_range(1, 5);
    for (int i = 0; i < n_hold; i++) begin
      send_beat(make_beat(1'b0, t, any_pulse(), any_pulse()));
      t += $urandom_range(0, dur / n_hold + 1);
    end
    if ($urandom_range(0, 3) != 0) begin
      t = ramp_t0 + dur + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 50));
      send_beat(make_beat(1'b0, t, any_pulse(), any_pulse()));
      repeat ($urandom_range(0, 2)) send_beat(make_beat(1'b0, $urandom(), any_pulse(),
                                                        any_pulse()));
    end
    clock_ms = t + 1;
  endtask

  // result side: random stalls with the odd long one and runs of steady ready,
  // plus one counted hold-off on request so the core backs up into its input
  initial begin : result_sink
    int unsigned   stall_left;
    int unsigned   steady_left;
    int unsigned   roll;
    pulse_result_t seen;
    stall_left   = 0;
    steady_left  = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        seen.write_valid = out_if.write_valid;
        seen.attach_req  = out_if.attach_req;
        seen.detach_req  = out_if.detach_req;
        seen.left_pulse  = out_if.left_pulse;
        seen.right_pulse = out_if.right_pulse;
        sb.check_output(seen);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
        steady_left  = 0;
      end
      if (stall_left == 0 && steady_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) steady_left = $urandom_range(100, 300);
        else if (roll < 5) stall_left = $urandom_range(20, 60);
        else if (roll < 30) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (steady_left > 0) steady_left--;
      end
    end
  end

  // a run that hangs ends here
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    gate_beat_t               b;
    logic [TIME_W-1:0]        clock_ms;
    logic [TIME_W-1:0]        t0;
    int unsigned              phase_start;
    logic [NEUTRAL_CFG_W-1:0] phase_neutral[6];
    logic [DUR_W-1:0]         phase_dur[6];

    // every core input known from time zero
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.drive_allowed   = 1'b0;
    in_if.commanded_left  = '0;
    in_if.commanded_right = '0;
    in_if.current_left    = '0;
    in_if.current_right   = '0;
    in_if.now_ms          = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_NEUTRAL;
    cfg_if.data           = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset registers first (neutral 1500, 500 ms) ----

    // pass-through with the command extremes on both sides
    b = make_beat(1'b1, 32'h0000_0000, 12'd4095, 12'd0);
    b.commanded_left  = 12'd0;
    b.commanded_right = 12'd4095;
    send_beat(b);
    b = make_beat(1'b1, 32'hFFFF_FFFF, 12'd0, 12'd4095);
    b.commanded_left  = 12'd4095;
    b.commanded_right = 12'd0;
    send_beat(b);

    // drive lost just before the time wrap, ramp crosses it and ends exactly at the duration
    send_beat(make_beat(1'b0, 32'hFFFF_FF00, 12'd0, 12'd4095));
    send_beat(make_beat(1'b0, 32'hFFFF_FFFA, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b0, 32'h0000_00C8, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b0, 32'h0000_00F4, any_pulse(), any_pulse()));
    // cut: nothing written
    send_beat(make_beat(1'b0, $urandom(), any_pulse(), any_pulse()));
    // drive back after a cut gives attach, the beat after does not
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));

    // elapsed well beyond the duration saturates straight to neutral
    t0 = $urandom();
    send_beat(make_beat(1'b0, t0, 12'd4095, 12'd0));
    send_beat(make_beat(1'b0, t0 + 32'd10000, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));

    // zero duration: immediate cut at neutral 0
    wait_idle(SETTLE_CYCLES);
    apply_gate_config(12'd0, 16'd0);
    send_beat(make_beat(1'b0, $urandom(), 12'd4095, 12'd4095));
    send_beat(make_beat(1'b0, $urandom(), any_pulse(), any_pulse()));
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));

    // longest ramp to the top neutral
    wait_idle(SETTLE_CYCLES);
    apply_gate_config(12'd4095, 16'hFFFF);
    t0 = 32'h8000_0000;
    send_beat(make_beat(1'b0, t0, 12'd0, 12'd0));
    send_beat(make_beat(1'b0, t0 + 32'd32767, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b0, t0 + 32'd65534, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b0, t0 + 32'd65535, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));

    // shortest non-zero ramp
    wait_idle(SETTLE_CYCLES);
    apply_gate_config(12'd2048, 16'd1);
    t0 = $urandom();
    send_beat(make_beat(1'b0, t0, 12'd1, 12'd4094));
    send_beat(make_beat(1'b0, t0 + 32'd1, any_pulse(), any_pulse()));
    send_beat(make_beat(1'b1, $urandom(), any_pulse(), any_pulse()));

    // ---- random part: one register setting per phase, extremes among them ----
    phase_neutral[0] = PB'($urandom());  phase_dur[0] = DUR_W'($urandom_range(1, 20));
    phase_neutral[1] = 12'd0;            phase_dur[1] = 16'd0;
    phase_neutral[2] = 12'd4095;         phase_dur[2] = 16'hFFFF;
    phase_neutral[3] = PB'($urandom());  phase_dur[3] = 16'd1;
    phase_neutral[4] = PB'($urandom());  phase_dur[4] = DUR_W'($urandom_range(21, 2000));
    phase_neutral[5] = PB'($urandom());  phase_dur[5] = DUR_W'($urandom());

    clock_ms = $urandom();
    for (int p = 0; p < 6; p++) begin
      wait_idle(SETTLE_CYCLES);
      apply_gate_config(phase_neutral[p], phase_dur[p]);
      // first phase: the result side holds off while beats keep coming
      if (p == 0) hold_off_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any drive state at any time
          repeat ($urandom_range(1, 3))
            send_beat(make_beat(1'($urandom_range(0, 1)), $urandom(), any_pulse(),
                                any_pulse()));
        end else begin
          run_episode(clock_ms);
        end
      end
    end

    wait_idle(DRAIN_CYCLES);
    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
